FILE: design/drpa_pkg.sv
// shared types and field widths for the decreasing run pile assigner
package drpa_pkg;

   localparam int VALUE_W      = 32;
   localparam int PILE_INDEX_W = 6;
   localparam int PILE_COUNT_W = 7;

   // controller to datapath
   typedef struct packed {
      logic load;    // take a new beat, set up the search window
      logic issue;   // read the pile top at the window midpoint
      logic step;    // compare and narrow the window
      logic commit;  // update the piles and load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic more;      // search window still holds piles
      logic out_busy;  // result register is full and not being taken
   } stat_type;

endpackage

FILE: design/decreasing_run_pile_assign.sv
// top level of the patience pile assigner: stream ports, controller, datapath, checks
//
// Each value beat is placed on the leftmost pile whose top is strictly greater than
// the value, found by binary search over the stored pile tops; the pile top is then
// replaced. If no top is greater, a new pile opens at the next index; if all
// MAX_PILES piles are in use, the value is dropped and the overflow flag is set. A
// start flag in req_tuser empties all piles before the value is placed. One value is
// in work at a time: after a beat is taken, each search step is one read of the pile
// top memory followed by one compare, then one state ends the search and one
// commits, and the next beat can be taken after the commit. The commit waits while
// the previous result is still held by rsp_tready low. The result sits in an output
// register, so the next beat is accepted while the previous result still waits for
// rsp_tready. Pile tops come up undefined after reset; only piles below the current
// count are ever read, so no clearing is needed.
module decreasing_run_pile_assign
   import drpa_pkg::*;
#(
   parameter int MAX_PILES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value (signed)
   input  logic [0:0]  req_tuser,  // [0] start_of_sequence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // [5:0] pile_index, [12:6] pile_count, [15:13] zero
   output logic [1:0]  rsp_tuser   // [0] opened_new_pile, [1] overflow
);

   cmd_type  cmd;
   stat_type stat;

   logic [PILE_INDEX_W-1:0] pile_index;
   logic [PILE_COUNT_W-1:0] pile_count;
   logic                    opened_new_pile;
   logic                    overflow;

   // sequencer: idle, search (issue read), read (compare), commit
   drpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // pile tops, search window, pile count and the result register
   drpa_dpath #(
      .MAX_PILES (MAX_PILES)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_value       ($signed(req_tdata)),
      .in_start       (req_tuser[0]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_pile_index (pile_index),
      .rsp_opened     (opened_new_pile),
      .rsp_pile_count (pile_count),
      .rsp_overflow   (overflow)
   );

   // pack the result beat, first field lowest
   assign rsp_tdata = {3'b000, pile_count, pile_index};
   assign rsp_tuser = {overflow, opened_new_pile};

   // a value either opens a pile or overflows, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(opened_new_pile && overflow))
      else $error("result flags both opened and overflow");

   // an overflow result always reports pile zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && overflow |-> pile_index == '0)
      else $error("overflow result with nonzero pile index");

   // a newly opened pile is the last one, so the count is its index plus one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && opened_new_pile && (MAX_PILES <= 64)
         |-> pile_count == PILE_COUNT_W'(pile_index) + PILE_COUNT_W'(1))
      else $error("opened pile is not the last pile");

   // one value in work at a time: no beat taken right after an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat accepted while a value is in work");

endmodule

FILE: design/drpa_ctrl.sv
// sequencer for the binary search over the pile tops
module drpa_ctrl
   import drpa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SEARCH = 4'b0010,
      ST_READ   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.more) begin
               cmd.issue = 1'b1;
               state_in  = ST_READ;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_READ: begin
            cmd.step = 1'b1;
            state_in = ST_SEARCH;
         end
         ST_COMMIT: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/drpa_dpath.sv
// pile top memory, search window registers, pile count and result register
module drpa_dpath
   import drpa_pkg::*;
#(
   parameter int MAX_PILES = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output stat_type                  stat,
   input  logic signed [VALUE_W-1:0] in_value,
   input  logic                      in_start,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PILE_INDEX_W-1:0]   rsp_pile_index,
   output logic                      rsp_opened,
   output logic [PILE_COUNT_W-1:0]   rsp_pile_count,
   output logic                      rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_PILES);
   localparam int CNT_W = $clog2(MAX_PILES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PILES);

   logic signed [VALUE_W-1:0] pile_tops_mem [MAX_PILES];

   logic signed [VALUE_W-1:0] key_ff;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          lo_ff;
   logic [CNT_W-1:0]          hi_ff;
   logic [CNT_W-1:0]          mid_ff;
   logic [CNT_W-1:0]          mid;

   logic                      rsp_valid_ff;
   logic [PILE_INDEX_W-1:0]   idx_ff;
   logic                      opened_ff;
   logic [PILE_COUNT_W-1:0]   cnt_out_ff;
   logic                      ovf_ff;

   logic                      found;
   logic                      room;
   logic                      wr_en;
   logic [CNT_W-1:0]          wr_pos;
   logic [CNT_W-1:0]          count_in;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   assign stat.more     = (lo_ff < hi_ff);
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   // placement decision at the end of the search: lo is the leftmost taller top
   assign found    = (lo_ff < count_ff);
   assign room     = (count_ff < MAX_CNT);
   assign wr_en    = cmd.commit && (found || room);
   assign wr_pos   = found ? lo_ff : count_ff;
   assign count_in = (!found && room) ? count_ff + CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_data_ff <= pile_tops_mem[mid[IDX_W-1:0]];
      end
      if (wr_en) begin
         pile_tops_mem[wr_pos[IDX_W-1:0]] <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= in_value;
         lo_ff  <= '0;
         hi_ff  <= in_start ? '0 : count_ff;
      end else if (cmd.step) begin
         if (rd_data_ff > key_ff) begin
            hi_ff <= mid_ff;
         end else begin
            lo_ff <= mid_ff + CNT_W'(1);
         end
      end
      if (cmd.issue) begin
         mid_ff <= mid;
      end
      if (cmd.commit) begin
         idx_ff     <= (found || room) ? PILE_INDEX_W'(wr_pos) : '0;
         opened_ff  <= !found && room;
         ovf_ff     <= !found && !room;
         cnt_out_ff <= PILE_COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load && in_start) begin
            count_ff <= '0;
         end else if (cmd.commit) begin
            count_ff <= count_in;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pile_index = idx_ff;
   assign rsp_opened     = opened_ff;
   assign rsp_pile_count = cnt_out_ff;
   assign rsp_overflow   = ovf_ff;

endmodule
